/* hw/rtl/isfc_pkg.sv */
`timescale 1ns / 1ps

package isfc_pkg;

    // Signal format: signed Q7.8 by default
    localparam int SIGNAL_WIDTH = 16;
    localparam int FRAC_BITS    = 8;
    localparam int INTEG_EXTRA  = 8;
    localparam int NUM_LANES    = 4;
    localparam int CFG_INDEX_WIDTH = 3;

    // Configuration register map
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_GAIN_STATE_SPEED       = 3'd0,
        REG_GAIN_STATE_VERTICAL    = 3'd1,
        REG_GAIN_STATE_RATE        = 3'd2,
        REG_GAIN_STATE_ANGLE       = 3'd3,
        REG_GAIN_INTEGRAL_SPEED    = 3'd4,
        REG_GAIN_INTEGRAL_VERTICAL = 3'd5,
        REG_GAIN_INTEGRAL_RATE     = 3'd6,
        REG_GAIN_INTEGRAL_ANGLE    = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [SIGNAL_WIDTH-1:0] forward_speed;
        logic signed [SIGNAL_WIDTH-1:0] vertical_speed;
        logic signed [SIGNAL_WIDTH-1:0] pitch_rate;
        logic signed [SIGNAL_WIDTH-1:0] pitch_angle;
        logic                           setpoint_valid;
        logic signed [SIGNAL_WIDTH-1:0] target_forward_speed;
        logic signed [SIGNAL_WIDTH-1:0] target_vertical_speed;
        logic signed [SIGNAL_WIDTH-1:0] target_pitch_rate;
        logic signed [SIGNAL_WIDTH-1:0] target_pitch_angle;
    } in_item_t;

    typedef struct packed {
        logic signed [SIGNAL_WIDTH-1:0] pitch_drive;
        logic                           drive_saturated;
    } out_item_t;

    // Stage load strobes for one lane
    typedef struct packed {
        logic load_mul;
        logic load_sum;
    } lane_ctrl_t;

endpackage

/* hw/rtl/integral_state_feedback_controller_core.sv */
`timescale 1ns / 1ps

// Integral state feedback controller (LQI with integral action).
// Input channel (in_valid/in_ready/in_item): one transfer carries the four
// state samples and, when setpoint_valid is set, a new setpoint. Output
// channel (out_valid/out_ready/out_item): one pitch drive transfer per input
// item once any setpoint has been seen; items before the first setpoint
// give no output.
// Config port: cfg_we writes cfg_data to the gain named by cfg_index in the
// same cycle; write only while the block is idle.
// Pipeline registers, in order: state capture, four multiply lanes, lane
// combine, merge/round/saturate into the output register. Throughput: one
// item per cycle while out_ready does not stall the output; the integrator
// update is one saturating add per element done in the accept cycle.
// Each stage refills as soon as its successor moves, so bubbles are
// squeezed out and inputs keep flowing while a result waits; in_ready drops
// only when all four stages hold items and out_ready is low.
// Reset clears gains, setpoint, integrators and all valid flags.
module integral_state_feedback_controller_core (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  isfc_pkg::in_item_t                         in_item,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output isfc_pkg::out_item_t                        out_item,
    input  logic                                       cfg_we,
    input  logic [isfc_pkg::CFG_INDEX_WIDTH-1:0]       cfg_index,
    input  logic [isfc_pkg::SIGNAL_WIDTH-1:0]          cfg_data
);

    localparam int SIGNAL_WIDTH = isfc_pkg::SIGNAL_WIDTH;
    localparam int NL = isfc_pkg::NUM_LANES;
    localparam int IW = SIGNAL_WIDTH + isfc_pkg::INTEG_EXTRA;
    localparam int EW = IW + 2;
    localparam int LW = 2 * SIGNAL_WIDTH + isfc_pkg::INTEG_EXTRA + 1;
    localparam logic signed [EW-1:0] INTEG_MAX = {3'b000, {(IW-1){1'b1}}};
    localparam logic signed [EW-1:0] INTEG_MIN = ~INTEG_MAX;

    logic signed [SIGNAL_WIDTH-1:0] gain_state_reg [NL];
    logic signed [SIGNAL_WIDTH-1:0] gain_integ_reg [NL];
    logic signed [SIGNAL_WIDTH-1:0] setpoint_reg   [NL];
    logic signed [SIGNAL_WIDTH-1:0] setpoint_next  [NL];
    logic signed [IW-1:0]           integ_reg      [NL];
    logic signed [IW-1:0]           integ_next     [NL];
    logic signed [SIGNAL_WIDTH-1:0] x_in           [NL];
    logic signed [SIGNAL_WIDTH-1:0] target_in      [NL];
    logic signed [SIGNAL_WIDTH-1:0] x_reg          [NL];
    logic signed [IW-1:0]           integ_old_reg  [NL];
    logic signed [EW-1:0]           integ_sum      [NL];
    logic signed [LW-1:0]           lane_sum       [NL];
    logic                           seen_reg;
    logic                           seen_next;
    logic                           accept;
    logic                           v1_reg;
    logic                           v2_reg;
    logic                           v3_reg;
    logic                           v4_reg;
    logic                           load1;
    logic                           load2;
    logic                           load3;
    logic                           load4;
    isfc_pkg::lane_ctrl_t           lane_ctrl;
    logic signed [SIGNAL_WIDTH-1:0] pitch_drive;
    logic                           drive_saturated;

    // Unpack the input item into per-lane elements
    always_comb
    begin
        x_in[0]      = SIGNAL_WIDTH'(in_item.forward_speed);
        x_in[1]      = SIGNAL_WIDTH'(in_item.vertical_speed);
        x_in[2]      = SIGNAL_WIDTH'(in_item.pitch_rate);
        x_in[3]      = SIGNAL_WIDTH'(in_item.pitch_angle);
        target_in[0] = SIGNAL_WIDTH'(in_item.target_forward_speed);
        target_in[1] = SIGNAL_WIDTH'(in_item.target_vertical_speed);
        target_in[2] = SIGNAL_WIDTH'(in_item.target_pitch_rate);
        target_in[3] = SIGNAL_WIDTH'(in_item.target_pitch_angle);
    end

    // Stage load chain: a stage loads when empty or when its successor loads
    assign load4     = !v4_reg || out_ready;
    assign load3     = !v3_reg || load4;
    assign load2     = !v2_reg || load3;
    assign load1     = !v1_reg || load2;
    assign in_ready  = load1;
    assign accept    = in_valid && in_ready;
    assign seen_next = seen_reg || in_item.setpoint_valid;

    // Pick the setpoint and form the saturated integrator update
    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            setpoint_next[i] = in_item.setpoint_valid ? target_in[i] : setpoint_reg[i];
            integ_sum[i] = EW'(integ_reg[i]) + EW'(setpoint_next[i]) - EW'(x_in[i]);
            if (integ_sum[i] > INTEG_MAX)
            begin
                integ_next[i] = INTEG_MAX[IW-1:0];
            end
            else if (integ_sum[i] < INTEG_MIN)
            begin
                integ_next[i] = INTEG_MIN[IW-1:0];
            end
            else
            begin
                integ_next[i] = integ_sum[i][IW-1:0];
            end
        end
    end

    // Hold gains, setpoint, integrators and the seen flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
            for (int i = 0; i < NL; i++)
            begin
                gain_state_reg[i] <= '0;
                gain_integ_reg[i] <= '0;
                setpoint_reg[i]   <= '0;
                integ_reg[i]      <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index >= isfc_pkg::REG_GAIN_INTEGRAL_SPEED)
                begin
                    gain_integ_reg[cfg_index[1:0]] <= cfg_data;
                end
                else
                begin
                    gain_state_reg[cfg_index[1:0]] <= cfg_data;
                end
            end
            if (accept && seen_next)
            begin
                seen_reg <= 1'b1;
                for (int i = 0; i < NL; i++)
                begin
                    setpoint_reg[i] <= setpoint_next[i];
                    integ_reg[i]    <= integ_next[i];
                end
            end
        end
    end

    // Capture the state and the pre-update integrators for the lanes
    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            for (int i = 0; i < NL; i++)
            begin
                x_reg[i]         <= x_in[i];
                integ_old_reg[i] <= integ_reg[i];
            end
        end
    end

    // Advance the stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (load1)
            begin
                v1_reg <= accept && seen_next;
            end
            if (load2)
            begin
                v2_reg <= v1_reg;
            end
            if (load3)
            begin
                v3_reg <= v2_reg;
            end
            if (load4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    assign lane_ctrl.load_mul = load2;
    assign lane_ctrl.load_sum = load3;

    // One lane per state element
    for (genvar g = 0; g < NL; g++)
    begin : g_lane
        isfc_lane #(
            .SIGNAL_WIDTH (SIGNAL_WIDTH)
        ) u_lane (
            .clk        (clk),
            .ctrl       (lane_ctrl),
            .gain_state (gain_state_reg[g]),
            .gain_integ (gain_integ_reg[g]),
            .state_x    (x_reg[g]),
            .integ      (integ_old_reg[g]),
            .lane_sum   (lane_sum[g])
        );
    end

    isfc_merge #(
        .SIGNAL_WIDTH (SIGNAL_WIDTH)
    ) u_merge (
        .clk             (clk),
        .load            (load4),
        .lane_sum        (lane_sum),
        .pitch_drive     (pitch_drive),
        .drive_saturated (drive_saturated)
    );

    assign out_valid                = v4_reg;
    assign out_item.pitch_drive     = pitch_drive;
    assign out_item.drive_saturated = drive_saturated;

endmodule

/* hw/rtl/isfc_lane.sv */
`timescale 1ns / 1ps

module isfc_lane #(
    parameter int SIGNAL_WIDTH = isfc_pkg::SIGNAL_WIDTH
) (
    input  logic                                  clk,
    input  isfc_pkg::lane_ctrl_t                  ctrl,
    input  logic signed [SIGNAL_WIDTH-1:0]        gain_state,
    input  logic signed [SIGNAL_WIDTH-1:0]        gain_integ,
    input  logic signed [SIGNAL_WIDTH-1:0]        state_x,
    input  logic signed [SIGNAL_WIDTH+isfc_pkg::INTEG_EXTRA-1:0] integ,
    output logic signed [2*SIGNAL_WIDTH+isfc_pkg::INTEG_EXTRA:0] lane_sum
);

    localparam int IW  = SIGNAL_WIDTH + isfc_pkg::INTEG_EXTRA;
    localparam int PSW = 2 * SIGNAL_WIDTH;
    localparam int PIW = SIGNAL_WIDTH + IW;
    localparam int LW  = PIW + 1;

    logic signed [PSW-1:0] prod_state_next;
    logic signed [PIW-1:0] prod_integ_next;
    logic signed [PSW-1:0] prod_state_reg;
    logic signed [PIW-1:0] prod_integ_reg;
    logic signed [LW-1:0]  lane_sum_next;
    logic signed [LW-1:0]  lane_sum_reg;

    // Form both exact products of this element
    always_comb
    begin
        prod_state_next = PSW'(gain_state) * PSW'(state_x);
        prod_integ_next = PIW'(gain_integ) * PIW'(integ);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_mul)
        begin
            prod_state_reg <= prod_state_next;
            prod_integ_reg <= prod_integ_next;
        end
    end

    // Combine: integral term minus state term
    assign lane_sum_next = LW'(prod_integ_reg) - LW'(prod_state_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.load_sum)
        begin
            lane_sum_reg <= lane_sum_next;
        end
    end

    assign lane_sum = lane_sum_reg;

endmodule

/* hw/rtl/isfc_merge.sv */
`timescale 1ns / 1ps

module isfc_merge #(
    parameter int SIGNAL_WIDTH = isfc_pkg::SIGNAL_WIDTH
) (
    input  logic                                  clk,
    input  logic                                  load,
    input  logic signed [2*SIGNAL_WIDTH+isfc_pkg::INTEG_EXTRA:0]
                                                  lane_sum [isfc_pkg::NUM_LANES],
    output logic signed [SIGNAL_WIDTH-1:0]        pitch_drive,
    output logic                                  drive_saturated
);

    localparam int LW = 2 * SIGNAL_WIDTH + isfc_pkg::INTEG_EXTRA + 1;
    localparam int SW = LW + 2;
    localparam logic signed [SW-1:0] ROUND_BIAS =
        SW'(1 << (isfc_pkg::FRAC_BITS - 1));
    localparam logic signed [SW-1:0] DRIVE_MAX =
        {{(SW-SIGNAL_WIDTH+1){1'b0}}, {(SIGNAL_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] DRIVE_MIN = ~DRIVE_MAX;

    logic signed [SW-1:0]           pair_a;
    logic signed [SW-1:0]           pair_b;
    logic signed [SW-1:0]           total;
    logic signed [SW-1:0]           scaled;
    logic signed [SIGNAL_WIDTH-1:0] drive_next;
    logic                           sat_next;
    logic signed [SIGNAL_WIDTH-1:0] pitch_drive_reg;
    logic                           drive_saturated_reg;

    // Sum the lanes, round half up and drop the fraction
    always_comb
    begin
        pair_a = SW'(lane_sum[0]) + SW'(lane_sum[1]);
        pair_b = SW'(lane_sum[2]) + SW'(lane_sum[3]);
        total  = pair_a + pair_b + ROUND_BIAS;
        scaled = total >>> isfc_pkg::FRAC_BITS;
    end

    // Clamp to the signal range and flag clipping
    always_comb
    begin
        if (scaled > DRIVE_MAX)
        begin
            drive_next = DRIVE_MAX[SIGNAL_WIDTH-1:0];
            sat_next   = 1'b1;
        end
        else if (scaled < DRIVE_MIN)
        begin
            drive_next = DRIVE_MIN[SIGNAL_WIDTH-1:0];
            sat_next   = 1'b1;
        end
        else
        begin
            drive_next = scaled[SIGNAL_WIDTH-1:0];
            sat_next   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pitch_drive_reg     <= drive_next;
            drive_saturated_reg <= sat_next;
        end
    end

    assign pitch_drive     = pitch_drive_reg;
    assign drive_saturated = drive_saturated_reg;

endmodule

/* hw/rtl/isfc_checker.sv */
`timescale 1ns / 1ps

module isfc_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input isfc_pkg::out_item_t                  out_item
);

    localparam int W = isfc_pkg::SIGNAL_WIDTH;
    localparam logic signed [W-1:0] DRIVE_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] DRIVE_MIN = {1'b1, {(W-1){1'b0}}};

    // A stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result changed or dropped");

    // An empty output stage never blocks input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("input blocked with no result pending");

    // A clipped drive sits at a range limit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.drive_saturated |->
            (out_item.pitch_drive == DRIVE_MAX) || (out_item.pitch_drive == DRIVE_MIN))
    else $error("saturation flag without a limit value");

    // No result right out of reset
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
    else $error("result present after reset");

    // A result cannot come out faster than the pipeline depth after reset
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> ##3 !out_valid)
    else $error("result faster than the pipeline depth");

endmodule

bind integral_state_feedback_controller_core isfc_checker u_isfc_checker (.*);
